### rtl/core/segregated_page_block_allocator_defines.svh
// Assertion macros used by the allocator checker
`ifndef SEGREGATED_PAGE_BLOCK_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_PAGE_BLOCK_ALLOCATOR_DEFINES_SVH

// Check a property on every rising edge outside reset
`define SPBA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("allocator check failed");

// Check a property on every rising edge, reset included
`define SPBA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("allocator check failed");

`endif

### rtl/core/spba_pkg.sv
// Types and codes of the segregated page block allocator
package spba_pkg;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_EXTEND = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_SPACE   = 3'd1;
   localparam logic [2:0] ST_INVALID    = 3'd2;
   localparam logic [2:0] ST_MIDDLE     = 3'd3;
   localparam logic [2:0] ST_POOL_FULL  = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [18:0] req_size;
      logic [17:0] obj_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [17:0] out_offset;
      logic [18:0] out_size;
   } rsp_type;

   typedef struct packed {
      logic       next;
      logic       prev;
      logic       alloc;
      logic       valid;
      logic [3:0] idx;
   } flags_type;

endpackage

### rtl/core/spba_bucket_sel.sv
// Bucket index for a sub-page request size
module spba_bucket_sel import spba_pkg::*; #(
   parameter int PAGE_SHIFT  = 12,
   parameter int GRAIN_SHIFT = 5,
   parameter int BW          = 3
) (
   input  logic [18:0]   req_size,
   output logic [BW-1:0] bkt
);

   localparam int NB = PAGE_SHIFT - GRAIN_SHIFT + 1;

   always_comb begin
      bkt = '0;
      // thresholds rise, so the last one exceeded wins
      for (int k = 0; k < NB - 1; k++) begin
         if (32'(req_size) > (32'(1) << (GRAIN_SHIFT + k))) begin
            bkt = BW'(k + 1);
         end
      end
   end

endmodule

### rtl/core/segregated_page_block_allocator.sv
// Segregated page and block allocator: sequencer over flag, run and link memories
// Steps: extend, and a free or query settled by the offset alone, respond from idle;
//   a free of a block or one page and a query of one page or block read the flags first;
//   a pop from a non-empty bucket reads the link memory, then responds. A run walk reads
//   each run visited, marks each page and relinks; a refill carves up to 2^(PAGE-GRAIN)
//   blocks, then pops. One request at a time; a run free or query steps page by page.
// Reset: synchronous; a clearing pass over all pages holds busy high, no stall input.
module segregated_page_block_allocator import spba_pkg::*; #(
   parameter int NUM_PAGES   = 64,
   parameter int PAGE_SHIFT  = 12,
   parameter int GRAIN_SHIFT = 5,
   parameter int INIT_PAGES  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int PW          = $clog2(NUM_PAGES);
   localparam int LW          = $clog2(NUM_PAGES + 1);
   localparam int AW          = PW + PAGE_SHIFT;
   localparam int LDW         = AW - GRAIN_SHIFT;
   localparam int LINK_DEPTH  = NUM_PAGES << (PAGE_SHIFT - GRAIN_SHIFT);
   localparam int NB          = PAGE_SHIFT - GRAIN_SHIFT + 1;
   localparam int BW          = (NB > 1) ? $clog2(NB) : 1;
   localparam int NW          = 20 - PAGE_SHIFT;
   localparam int CW          = PAGE_SHIFT - GRAIN_SHIFT + 1;
   localparam int START_PAGES = (INIT_PAGES < NUM_PAGES) ? INIT_PAGES : NUM_PAGES;
   localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;

   typedef struct packed {
      logic [PW-1:0] nxt;
      logic [LW-1:0] len;
   } run_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WALK, S_CHECK, S_MARK, S_LINK, S_CARVE, S_POP_RD, S_POP,
      S_FREE_CHK, S_FREE_RUN, S_QRY_CHK, S_QRY_RUN
   } state_type;

   // memories
   flags_type     flags_mem [NUM_PAGES];
   run_type       run_mem   [NUM_PAGES];
   logic [AW-1:0] link_mem  [LINK_DEPTH];

   flags_type      flags_q, flags_wd;
   run_type        run_q, run_wd;
   logic [AW-1:0]  link_q, link_wd;
   logic           flags_we, run_we, link_we;
   logic [PW-1:0]  flags_wa, flags_ra, run_wa, run_ra;
   logic [LDW-1:0] link_wa, link_ra;

   always_ff @(posedge clock) begin
      if (flags_we) flags_mem[flags_wa] <= flags_wd;
      flags_q <= flags_mem[flags_ra];
      if (run_we) run_mem[run_wa] <= run_wd;
      run_q <= run_mem[run_ra];
      if (link_we) link_mem[link_wa] <= link_wd;
      link_q <= link_mem[link_ra];
   end

   // registers
   state_type     state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [PW-1:0] cur_ff, cur_in, prev_ff, prev_in, repl_ff, repl_in, pp_ff, pp_in;
   logic [PW-1:0] clr_ff, clr_in, free_head_ff, free_head_in;
   logic [LW-1:0] prev_len_ff, prev_len_in, len_ff, len_in, walk_ff, walk_in;
   logic [LW-1:0] cnt_ff, cnt_in, piu_ff, piu_in;
   logic [NW-1:0] need_ff, need_in, k_ff, k_in;
   logic [BW-1:0] bkt_ff, bkt_in, bkt_sel;
   logic          is_bkt_ff, is_bkt_in;
   logic [CW-1:0] cv_ff, cv_in;
   logic [AW-1:0] carve_ff, carve_in;
   logic [AW-1:0] head_ff [NB];
   logic [AW-1:0] head_in [NB];
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // response and scratch
   logic          resp_go;
   logic [2:0]    resp_status;
   logic [31:0]   resp_off, resp_size;
   logic [31:0]   page32, add32, repl32, pg32, a32, bs32;
   flags_type     fl;

   spba_bucket_sel #(
      .PAGE_SHIFT  (PAGE_SHIFT),
      .GRAIN_SHIFT (GRAIN_SHIFT),
      .BW          (BW)
   ) u_bucket_sel (
      .req_size (req_data.req_size),
      .bkt      (bkt_sel)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      repl_in      = repl_ff;
      pp_in        = pp_ff;
      clr_in       = clr_ff;
      free_head_in = free_head_ff;
      prev_len_in  = prev_len_ff;
      len_in       = len_ff;
      walk_in      = walk_ff;
      cnt_in       = cnt_ff;
      piu_in       = piu_ff;
      need_in      = need_ff;
      k_in         = k_ff;
      bkt_in       = bkt_ff;
      is_bkt_in    = is_bkt_ff;
      cv_in        = cv_ff;
      carve_in     = carve_ff;
      head_in      = head_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      flags_we = 1'b0;
      flags_wa = '0;
      flags_wd = '0;
      flags_ra = '0;
      run_we   = 1'b0;
      run_wa   = '0;
      run_wd   = '0;
      run_ra   = '0;
      link_we  = 1'b0;
      link_wa  = '0;
      link_wd  = '0;
      link_ra  = '0;

      resp_go     = 1'b0;
      resp_status = ST_OK;
      resp_off    = '0;
      resp_size   = '0;

      page32 = 32'(req_data.obj_offset) >> PAGE_SHIFT;
      add32  = 32'(req_data.req_size) >> PAGE_SHIFT;
      repl32 = 32'(cur_ff) + 32'(need_ff);
      pg32   = 32'(cur_ff) + 32'(k_ff);
      bs32   = 32'(1) << (GRAIN_SHIFT + int'(bkt_ff));
      a32    = (32'(cur_ff) << PAGE_SHIFT) + (32'(cv_ff) << (GRAIN_SHIFT + int'(bkt_ff)));
      fl     = flags_q;

      case (state_ff)
         S_CLEAR: begin
            flags_we       = 1'b1;
            flags_wa       = clr_ff;
            flags_wd.alloc = (clr_ff == '0);
            run_we         = 1'b1;
            run_wa         = clr_ff;
            run_wd.len     = (clr_ff == PW'(1)) ? LW'(START_PAGES - 1) : '0;
            clr_in         = clr_ff + PW'(1);
            if (clr_ff == PW'(NUM_PAGES - 1)) state_in = S_IDLE;
         end

         S_IDLE: begin
            if (start) begin
               cmd_in = req_data;
               cur_in = page32[PW-1:0];
               case (req_data.mode)
                  MODE_ALLOC: begin
                     if (32'(req_data.req_size) < PAGE_BYTES) begin
                        bkt_in    = bkt_sel;
                        is_bkt_in = 1'b1;
                        need_in   = NW'(1);
                     end else begin
                        is_bkt_in = 1'b0;
                        need_in   = NW'((32'(req_data.req_size) + PAGE_BYTES - 1)
                                        >> PAGE_SHIFT);
                     end
                     if (32'(req_data.req_size) < PAGE_BYTES && head_ff[bkt_sel] != '0) begin
                        state_in = S_POP_RD;
                     end else begin
                        cur_in   = free_head_ff;
                        prev_in  = '0;
                        walk_in  = '0;
                        state_in = S_WALK;
                     end
                  end
                  MODE_FREE: begin
                     if (req_data.obj_offset == '0) begin
                        resp_go = 1'b1;
                     end else if (page32 == '0 || page32 >= NUM_PAGES) begin
                        resp_go     = 1'b1;
                        resp_status = ST_INVALID;
                     end else begin
                        flags_ra = page32[PW-1:0];
                        state_in = S_FREE_CHK;
                     end
                  end
                  MODE_QUERY: begin
                     if (page32 >= NUM_PAGES) begin
                        resp_go   = 1'b1;
                        resp_size = PAGE_BYTES;
                     end else begin
                        flags_ra = page32[PW-1:0];
                        state_in = S_QRY_CHK;
                     end
                  end
                  default: begin
                     resp_go = 1'b1;
                     if (add32 == '0) begin
                        resp_status = ST_OK;
                     end else if (32'(piu_ff) + add32 > NUM_PAGES || 32'(piu_ff) >= NUM_PAGES) begin
                        resp_status = ST_POOL_FULL;
                     end else begin
                        run_we       = 1'b1;
                        run_wa       = piu_ff[PW-1:0];
                        run_wd.nxt   = free_head_ff;
                        run_wd.len   = LW'(add32);
                        free_head_in = piu_ff[PW-1:0];
                        piu_in       = LW'(32'(piu_ff) + add32);
                     end
                  end
               endcase
            end
         end

         S_WALK: begin
            if (cur_ff == '0 || 32'(cur_ff) >= NUM_PAGES) begin
               resp_go     = 1'b1;
               resp_status = ST_NO_SPACE;
            end else begin
               run_ra   = cur_ff;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            if (32'(run_q.len) >= 32'(need_ff)) begin
               len_in = run_q.len;
               if (32'(run_q.len) > 32'(need_ff)) begin
                  // remainder stays in place as a run that replaces this one
                  if (repl32 < NUM_PAGES) begin
                     run_we     = 1'b1;
                     run_wa     = repl32[PW-1:0];
                     run_wd.nxt = run_q.nxt;
                     run_wd.len = LW'(32'(run_q.len) - 32'(need_ff));
                  end
                  repl_in = repl32[PW-1:0];
               end else begin
                  repl_in = run_q.nxt;
               end
               k_in     = '0;
               state_in = S_MARK;
            end else if (32'(walk_ff) == NUM_PAGES) begin
               resp_go     = 1'b1;
               resp_status = ST_NO_SPACE;
            end else begin
               prev_in     = cur_ff;
               prev_len_in = run_q.len;
               cur_in      = run_q.nxt;
               walk_in     = walk_ff + LW'(1);
               state_in    = S_WALK;
            end
         end

         S_MARK: begin
            if (pg32 < NUM_PAGES) begin
               flags_we       = 1'b1;
               flags_wa       = pg32[PW-1:0];
               flags_wd.next  = (32'(k_ff) + 1 < 32'(need_ff));
               flags_wd.prev  = (k_ff != '0);
               flags_wd.alloc = 1'b1;
               flags_wd.valid = is_bkt_ff;
               flags_wd.idx   = is_bkt_ff ? 4'(bkt_ff) : 4'd0;
            end
            k_in = k_ff + NW'(1);
            if (32'(k_ff) + 1 >= 32'(need_ff)) state_in = S_LINK;
         end

         S_LINK: begin
            if (prev_ff != '0) begin
               run_we     = 1'b1;
               run_wa     = prev_ff;
               run_wd.nxt = repl_ff;
               run_wd.len = (prev_ff == repl_ff && 32'(len_ff) > 32'(need_ff)) ?
                            LW'(32'(len_ff) - 32'(need_ff)) : prev_len_ff;
            end else begin
               free_head_in = repl_ff;
            end
            if (is_bkt_ff) begin
               cv_in    = '0;
               state_in = S_CARVE;
            end else begin
               resp_go   = 1'b1;
               resp_off  = 32'(cur_ff) << PAGE_SHIFT;
               resp_size = 32'(need_ff) << PAGE_SHIFT;
            end
         end

         S_CARVE: begin
            // push blocks in rising address order; the last one becomes the head
            link_we  = 1'b1;
            link_wa  = LDW'(a32 >> GRAIN_SHIFT);
            link_wd  = (cv_ff == '0) ? head_ff[bkt_ff] : carve_ff;
            carve_in = AW'(a32);
            cv_in    = cv_ff + CW'(1);
            if (32'(cv_ff) + 1 == (32'(1) << (PAGE_SHIFT - GRAIN_SHIFT - int'(bkt_ff)))) begin
               head_in[bkt_ff] = AW'(a32);
               state_in        = S_POP_RD;
            end
         end

         S_POP_RD: begin
            link_ra  = LDW'(head_ff[bkt_ff] >> GRAIN_SHIFT);
            state_in = S_POP;
         end

         S_POP: begin
            resp_go         = 1'b1;
            resp_off        = 32'(head_ff[bkt_ff]);
            resp_size       = bs32;
            head_in[bkt_ff] = link_q;
         end

         S_FREE_CHK: begin
            if (!fl.alloc) begin
               resp_go     = 1'b1;
               resp_status = ST_INVALID;
            end else if (fl.valid) begin
               resp_go = 1'b1;
               if (32'(fl.idx) < NB) begin
                  a32     = 32'(cmd_ff.obj_offset) &
                            ~((32'(1) << (GRAIN_SHIFT + int'(fl.idx))) - 32'(1));
                  link_we = 1'b1;
                  link_wa = LDW'(a32 >> GRAIN_SHIFT);
                  link_wd = head_ff[fl.idx[BW-1:0]];
                  head_in[fl.idx[BW-1:0]] = AW'(a32);
               end else begin
                  resp_status = ST_INVALID;
               end
            end else if (fl.prev) begin
               resp_go     = 1'b1;
               resp_status = ST_MIDDLE;
            end else begin
               flags_we = 1'b1;
               flags_wa = cur_ff;
               cnt_in   = LW'(1);
               if (fl.next && 32'(cur_ff) + 1 < NUM_PAGES) begin
                  flags_ra = cur_ff + PW'(1);
                  pp_in    = cur_ff + PW'(1);
                  state_in = S_FREE_RUN;
               end else begin
                  resp_go      = 1'b1;
                  run_we       = 1'b1;
                  run_wa       = cur_ff;
                  run_wd.nxt   = free_head_ff;
                  run_wd.len   = LW'(1);
                  free_head_in = cur_ff;
               end
            end
         end

         S_FREE_RUN: begin
            flags_we = 1'b1;
            flags_wa = pp_ff;
            cnt_in   = cnt_ff + LW'(1);
            if (fl.next && 32'(pp_ff) + 1 < NUM_PAGES) begin
               flags_ra = pp_ff + PW'(1);
               pp_in    = pp_ff + PW'(1);
            end else begin
               resp_go      = 1'b1;
               run_we       = 1'b1;
               run_wa       = cur_ff;
               run_wd.nxt   = free_head_ff;
               run_wd.len   = cnt_ff + LW'(1);
               free_head_in = cur_ff;
            end
         end

         S_QRY_CHK: begin
            if (fl.valid) begin
               resp_go   = 1'b1;
               resp_size = (32'(1) << GRAIN_SHIFT) << fl.idx;
            end else if (fl.prev) begin
               resp_go     = 1'b1;
               resp_status = ST_MIDDLE;
            end else if (fl.next && 32'(cur_ff) + 1 < NUM_PAGES) begin
               flags_ra = cur_ff + PW'(1);
               pp_in    = cur_ff + PW'(1);
               cnt_in   = LW'(2);
               state_in = S_QRY_RUN;
            end else begin
               resp_go   = 1'b1;
               resp_size = PAGE_BYTES;
            end
         end

         S_QRY_RUN: begin
            if (fl.next && 32'(pp_ff) + 1 < NUM_PAGES) begin
               flags_ra = pp_ff + PW'(1);
               pp_in    = pp_ff + PW'(1);
               cnt_in   = cnt_ff + LW'(1);
            end else begin
               resp_go   = 1'b1;
               resp_size = 32'(cnt_ff) << PAGE_SHIFT;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (resp_go) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = resp_status;
         rsp_in.out_offset = resp_off[17:0];
         rsp_in.out_size   = resp_size[18:0];
         state_in          = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      repl_ff     <= repl_in;
      pp_ff       <= pp_in;
      prev_len_ff <= prev_len_in;
      len_ff      <= len_in;
      walk_ff     <= walk_in;
      cnt_ff      <= cnt_in;
      need_ff     <= need_in;
      k_ff        <= k_in;
      bkt_ff      <= bkt_in;
      is_bkt_ff   <= is_bkt_in;
      cv_ff       <= cv_in;
      carve_ff    <= carve_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= PW'(1);
         piu_ff       <= LW'(INIT_PAGES);
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NB; b++) head_ff[b] <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         piu_ff       <= piu_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/spba_checker.sv
// Port-level checks of the allocator and their attachment to the top level
`include "segregated_page_block_allocator_defines.svh"

module spba_checker import spba_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   `SPBA_ASSERT(a_status_range, clock, reset, rsp_valid |-> rsp_data.status <= ST_POOL_FULL)
   `SPBA_ASSERT(a_fail_empty, clock, reset, (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.out_offset == '0 && rsp_data.out_size == '0))
   `SPBA_ASSERT(a_offset_sized, clock, reset, (rsp_valid && rsp_data.out_offset != '0) |-> rsp_data.out_size != '0)
   `SPBA_ASSERT_ALWAYS(a_clear_after_reset, clock, $past(reset) |-> busy)

endmodule

bind segregated_page_block_allocator spba_checker u_spba_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
